@@ hdl/safe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// safe_pkg: shared types and constants for the slot allocator
// Request/response structs, opcode names, sequencer states, datapath widths.
// ----------------------------------------------------------------------------
package safe_pkg;

  localparam int COORD_W = 20;
  localparam int ID_W    = 10;
  localparam int DIFF_W  = COORD_W + 1;      // difference of two coordinates
  localparam int SHR_W   = DIFF_W - 8;       // after the >>> 8
  localparam int PROD_W  = 2 * SHR_W - 1;    // square of a SHR_W-bit signed value
  localparam int DIST_W  = PROD_W + 2;       // sum of three squares

  localparam logic [1:0] MODE_ENABLE  = 2'd0;
  localparam logic [1:0] MODE_DISABLE = 2'd1;
  localparam logic [1:0] MODE_UPDATE  = 2'd2;

  typedef struct packed {
    logic [1:0]                mode;
    logic [ID_W-1:0]           item_id;
    logic                      force_req;
    logic signed [COORD_W-1:0] item_x;
    logic signed [COORD_W-1:0] item_y;
    logic signed [COORD_W-1:0] item_z;
    logic signed [COORD_W-1:0] cam_x;
    logic signed [COORD_W-1:0] cam_y;
    logic signed [COORD_W-1:0] cam_z;
  } req_t;

  typedef struct packed {
    logic            accepted;
    logic [2:0]      slot_index;
    logic            evicted;
    logic [ID_W-1:0] evicted_item;
    logic [3:0]      slots_in_use;
  } rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]           owner;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SELF,
    ST_SCAN,
    ST_FIN,
    ST_DONE
  } state_t;

endpackage : safe_pkg
`default_nettype wire

@@ hdl/slot_allocator_farthest_eviction.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slot_allocator_farthest_eviction: slot table with farthest-slot eviction
// Allocates, frees and repositions item slots; when full, evicts the slot
// farthest from the camera if beyond the requester or forced; one squarer.
// ----------------------------------------------------------------------------
//  channel   ports                 transfer
//  --------  --------------------  -----------------------------------------
//  request   start, busy, req      rising edge with start high, busy low
//  response  done, rsp             one-cycle strobe on done, cannot stall
//
//  A request runs from its transfer to the response transfer through these
//  steps: square the requester, then for each slot close the previous sum
//  and square the slot, close the last sum, commit, and the strobe itself.
//  The steps are set by the single squarer: three axis squares per slot
//  plus a step to close each sum, swept over every slot through the one
//  read port of the slot memory.
//  busy is high from the cycle after a transfer until the response strobe.
//  Reset (rst, synchronous) frees every slot and clears the count; slot
//  contents are not cleared, a free slot's contents never affect a response.
// ----------------------------------------------------------------------------
module slot_allocator_farthest_eviction
  import safe_pkg::*;
#(
  parameter int SLOT_COUNT = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req,
  output logic      done,
  output rsp_t      rsp
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  // sequencer
  state_t state, state_next;
  logic [1:0]       ax;          // phase within a slot: 0 close sum, 1..3 x/y/z
  logic [IDX_W-1:0] idx;         // slot being read
  logic [IDX_W-1:0] prev_idx;    // slot whose sum is closed in phase 0
  logic             last;

  // latched request
  req_t rq;

  // slot table: valid bits in flops, contents in a memory
  logic [SLOT_COUNT-1:0] valid;
  entry_t                mem [SLOT_COUNT];
  entry_t                rd_data;
  logic [CNT_W-1:0]      used_count;
  logic                  full;

  // scan results
  logic             found, free_found, victim_found;
  logic [IDX_W-1:0] found_idx, free_idx, victim_idx;
  logic [ID_W-1:0]  victim_owner;
  logic [DIST_W-1:0] worst;

  // shared squarer and accumulator
  logic signed [COORD_W-1:0] op_p, op_c;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [SHR_W-1:0]   shr;
  logic signed [2*SHR_W-1:0] sq_full;
  logic [PROD_W-1:0]         prod;
  logic [DIST_W-1:0]         acc;
  logic [DIST_W-1:0]         dist_cur;

  // commit
  logic             wr_en, set_v, clr_v;
  logic [IDX_W-1:0] wr_idx;
  logic [CNT_W-1:0] cnt_next;
  rsp_t             rsp_next;
  logic [IDX_W+2:0] slot_ext;
  logic [CNT_W+3:0] cnt_ext;

  assign busy = (state != ST_IDLE);
  assign last = (idx == IDX_W'(SLOT_COUNT - 1));
  assign full = (used_count == CNT_W'(SLOT_COUNT));

  // ---- state register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) state_next = ST_SELF;
      ST_SELF: if (ax == 2'd3) state_next = ST_SCAN;
      ST_SCAN: if (ax == 2'd3 && last) state_next = ST_FIN;
      ST_FIN:  state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // ---- squarer: requester position in SELF, stored slot otherwise ----
  always_comb begin
    case (ax)
      2'd1:    begin op_p = (state == ST_SELF) ? rq.item_x : rd_data.pos_x; op_c = rq.cam_x; end
      2'd2:    begin op_p = (state == ST_SELF) ? rq.item_y : rd_data.pos_y; op_c = rq.cam_y; end
      default: begin op_p = (state == ST_SELF) ? rq.item_z : rd_data.pos_z; op_c = rq.cam_z; end
    endcase
  end

  assign diff     = DIFF_W'(op_p) - DIFF_W'(op_c);
  assign shr      = diff[DIFF_W-1:8];           // arithmetic >>> 8 (floor)
  assign sq_full  = shr * shr;
  assign dist_cur = acc + DIST_W'(prod);

  // ---- memory read port ----
  always_ff @(posedge clk) begin
    rd_data <= mem[idx];
  end

  // ---- sequencer counters and scan bookkeeping ----
  always_ff @(posedge clk) begin
    if (rst) begin
      ax           <= 2'd0;
      idx          <= '0;
      prev_idx     <= '0;
      found        <= 1'b0;
      free_found   <= 1'b0;
      victim_found <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            rq           <= req;
            ax           <= 2'd1;   // no sum to close before the first square
            idx          <= '0;
            found        <= 1'b0;
            free_found   <= 1'b0;
            victim_found <= 1'b0;
          end
        end
        ST_SELF, ST_SCAN: begin
          ax <= ax + 2'd1;
          if (ax != 2'd0) begin
            prod <= PROD_W'(sq_full);
          end
          if (ax == 2'd2) begin
            acc <= DIST_W'(prod);
          end
          if (ax == 2'd3) begin
            acc      <= dist_cur;
            prev_idx <= idx;
            if (state == ST_SCAN && !last) begin
              idx <= idx + IDX_W'(1);
            end
          end
          // close the previous sum: requester sets the threshold, slots compete
          if (state == ST_SCAN && ax == 2'd0) begin
            if (idx == '0) begin
              worst <= rq.force_req ? '0 : dist_cur;
            end else if (dist_cur > worst) begin
              worst        <= dist_cur;
              victim_found <= 1'b1;
              victim_idx   <= prev_idx;
              victim_owner <= rd_data.owner;
            end
          end
          // owner match and first free slot, data for idx is now in rd_data
          if (state == ST_SCAN && ax == 2'd1) begin
            if (valid[idx] && rd_data.owner == rq.item_id && !found) begin
              found     <= 1'b1;
              found_idx <= idx;
            end
            if (!valid[idx] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= idx;
            end
          end
        end
        ST_FIN: begin
          if (dist_cur > worst) begin
            worst        <= dist_cur;
            victim_found <= 1'b1;
            victim_idx   <= prev_idx;
            victim_owner <= rd_data.owner;
          end
        end
        default: ;
      endcase
    end
  end

  // ---- decision at the end of the sweep ----
  always_comb begin
    wr_en    = 1'b0;
    set_v    = 1'b0;
    clr_v    = 1'b0;
    wr_idx   = found_idx;
    cnt_next = used_count;
    rsp_next = '0;
    case (rq.mode)
      MODE_ENABLE: begin
        if (found) begin
          wr_en             = 1'b1;
          rsp_next.accepted = 1'b1;
        end else if (free_found) begin
          wr_en             = 1'b1;
          set_v             = 1'b1;
          wr_idx            = free_idx;
          cnt_next          = used_count + CNT_W'(1);
          rsp_next.accepted = 1'b1;
        end else if (full && victim_found) begin
          // eviction keeps the count: one slot out, one in
          wr_en                 = 1'b1;
          set_v                 = 1'b1;
          wr_idx                = victim_idx;
          rsp_next.accepted     = 1'b1;
          rsp_next.evicted      = 1'b1;
          rsp_next.evicted_item = victim_owner;
        end
      end
      MODE_DISABLE: begin
        if (found) begin
          clr_v             = 1'b1;
          cnt_next          = used_count - CNT_W'(1);
          rsp_next.accepted = 1'b1;
        end
      end
      MODE_UPDATE: begin
        if (found) begin
          wr_en             = 1'b1;
          rsp_next.accepted = 1'b1;
        end
      end
      default: ;
    endcase
    slot_ext = {3'b000, wr_idx};
    cnt_ext  = {4'b0000, cnt_next};
    if (rsp_next.accepted) begin
      rsp_next.slot_index = slot_ext[2:0];
    end
    rsp_next.slots_in_use = cnt_ext[3:0];
  end

  // ---- table update and response ----
  always_ff @(posedge clk) begin
    if (state == ST_DONE && wr_en) begin
      mem[wr_idx] <= '{owner: rq.item_id, pos_x: rq.item_x,
                       pos_y: rq.item_y, pos_z: rq.item_z};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      used_count <= '0;
      done       <= 1'b0;
    end else begin
      done <= (state == ST_DONE);
      if (state == ST_DONE) begin
        used_count <= cnt_next;
        rsp        <= rsp_next;
        if (set_v) valid[wr_idx] <= 1'b1;
        if (clr_v) valid[wr_idx] <= 1'b0;
      end
    end
  end

endmodule : slot_allocator_farthest_eviction
`default_nettype wire
